// ===== sv/swrd_pkg.sv =====
// Package for the SYN rate window detector: beat types, register indexes,
// controller state and the command/status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package swrd_pkg;

   localparam int ADDR_W     = 32;
   localparam int NOW_W      = 32;
   localparam int RECENT_W   = 5;
   localparam int WINDOW_W   = 8;
   localparam int THRESH_W   = 5;
   localparam int CSR_DATA_W = 8;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd5;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd10;

   typedef enum logic [0:0] {
      CSR_WINDOW_SECONDS,
      CSR_ALERT_THRESHOLD
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] source_address;
      logic [NOW_W-1:0]  now_seconds;
   } req_item_type;

   typedef struct packed {
      logic                alert;
      logic                dropped;
      logic [RECENT_W-1:0] recent_count;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CNT_WAIT,
      ST_SWEEP,
      ST_SHIFT,
      ST_APPEND
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic take_hit;
      logic load_count;
      logic claim;
      logic sweep;
      logic keep_all;
      logic shift_setup;
      logic append;
      logic drop;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
      logic table_full;
      logic sweep_end;
      logic hist_full;
   } ctl_status_type;

endpackage

// ===== sv/swrd_ctrl.sv =====
// Controller state machine of the SYN rate window detector.
// Depends on swrd_pkg; drives the datapath through ctl_cmd_type.
`timescale 1ns / 1ps

module swrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  swrd_pkg::ctl_status_type status,
   output swrd_pkg::ctl_cmd_type   cmd,
   output logic                    busy
);
   import swrd_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_CNT_WAIT;
            end else if (status.scan_end) begin
               if (status.table_full) begin
                  cmd.drop = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  // A new entry starts with an empty history.
                  cmd.claim = 1'b1;
                  state_in  = ST_APPEND;
               end
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_CNT_WAIT: begin
            cmd.load_count = 1'b1;
            state_in       = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (status.sweep_end) begin
               if (status.hist_full) begin
                  cmd.shift_setup = 1'b1;
                  state_in        = ST_SHIFT;
               end else begin
                  state_in = ST_APPEND;
               end
            end else begin
               cmd.sweep = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (status.sweep_end) begin
               state_in = ST_APPEND;
            end else begin
               cmd.sweep    = 1'b1;
               cmd.keep_all = 1'b1;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/swrd_datapath.sv =====
// Datapath of the SYN rate window detector: address tags, history counts and
// timestamp memory, scan and sweep counters, registers and the result register.
// Depends on swrd_pkg; controlled by swrd_ctrl.
`timescale 1ns / 1ps

module swrd_datapath #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int HISTORY_SLOTS = 16,
   parameter int TIME_WIDTH    = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swrd_pkg::req_item_type         req_item,
   input  logic                           csr_we,
   input  swrd_pkg::csr_index_type        csr_index,
   input  logic [swrd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  swrd_pkg::ctl_cmd_type          cmd,
   output swrd_pkg::ctl_status_type       status,
   output logic                           rsp_valid,
   output swrd_pkg::rsp_item_type         rsp_item
);
   import swrd_pkg::*;

   localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(HISTORY_SLOTS + 1);
   localparam int HADDR_W = $clog2(TABLE_ENTRIES * HISTORY_SLOTS);
   localparam int CMP_W   = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

   // Memories
   logic [ADDR_W-1:0]     tag_mem  [TABLE_ENTRIES];
   logic [CNT_W-1:0]      hcnt_mem [TABLE_ENTRIES];
   logic [TIME_WIDTH-1:0] time_mem [TABLE_ENTRIES * HISTORY_SLOTS];

   // Control registers
   logic [USED_W-1:0]   used_ff;
   logic [USED_W-1:0]   idx_ff;
   logic                pend_ff;
   logic                hpend_ff;
   logic [WINDOW_W-1:0] window_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic                rsp_valid_ff;

   // Payload registers
   req_item_type          item_ff;
   logic [ADDR_W-1:0]     tag_rd_ff;
   logic [ENTRY_W-1:0]    cmp_idx_ff;
   logic [ENTRY_W-1:0]    entry_ff;
   logic [HADDR_W-1:0]    base_ff;
   logic [CNT_W-1:0]      hcnt_rd_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      rd_slot_ff;
   logic [CNT_W-1:0]      wr_slot_ff;
   logic [TIME_WIDTH-1:0] time_rd_ff;
   rsp_item_type          rsp_ff;

   logic                  scan_issue;
   logic                  sweep_issue;
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] age;
   logic                  keep;
   logic                  time_we;
   logic [HADDR_W-1:0]    time_rd_addr;
   logic [HADDR_W-1:0]    time_wr_addr;
   logic [TIME_WIDTH-1:0] time_wr_data;
   logic [CNT_W-1:0]      new_cnt;
   logic                  alert_now;
   logic [CNT_W-1:0]      final_cnt;

   assign now_t        = TIME_WIDTH'(item_ff.now_seconds);
   assign scan_issue   = cmd.scan && (idx_ff < used_ff);
   assign sweep_issue  = cmd.sweep && (rd_slot_ff < cnt_ff);
   assign age          = now_t - time_rd_ff;
   assign keep         = cmd.keep_all || (age <= TIME_WIDTH'(window_ff));
   assign time_rd_addr = base_ff + HADDR_W'(rd_slot_ff);
   assign time_wr_addr = base_ff + HADDR_W'(wr_slot_ff);
   assign time_we      = cmd.append || (cmd.sweep && hpend_ff && keep);
   assign time_wr_data = cmd.append ? now_t : time_rd_ff;
   assign new_cnt      = wr_slot_ff + CNT_W'(1);
   assign alert_now    = CMP_W'(new_cnt) >= CMP_W'(threshold_ff);
   assign final_cnt    = alert_now ? '0 : new_cnt;

   assign status.hit        = pend_ff && (tag_rd_ff == item_ff.source_address);
   assign status.scan_end   = (idx_ff == used_ff) && !pend_ff;
   assign status.table_full = (used_ff == USED_W'(TABLE_ENTRIES));
   assign status.sweep_end  = (rd_slot_ff == cnt_ff) && !hpend_ff;
   assign status.hist_full  = (wr_slot_ff >= CNT_W'(HISTORY_SLOTS));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.claim) begin
         tag_mem[used_ff[ENTRY_W-1:0]] <= item_ff.source_address;
      end
      if (scan_issue) begin
         tag_rd_ff <= tag_mem[idx_ff[ENTRY_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         hcnt_mem[entry_ff] <= final_cnt;
      end
      if (cmd.take_hit) begin
         hcnt_rd_ff <= hcnt_mem[cmp_idx_ff];
      end
   end

   // Reads run ahead of writes during a sweep, so a slot is never read after
   // it has been overwritten.
   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_wr_addr] <= time_wr_data;
      end
      if (sweep_issue) begin
         time_rd_ff <= time_mem[time_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hpend_ff     <= 1'b0;
         window_ff    <= WINDOW_RESET;
         threshold_ff <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.append || cmd.drop;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW_SECONDS:  window_ff    <= csr_wdata[WINDOW_W-1:0];
               CSR_ALERT_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
               default:             window_ff    <= window_ff;
            endcase
         end
         if (cmd.load) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= scan_issue;
            if (scan_issue) begin
               idx_ff <= idx_ff + USED_W'(1);
            end
         end
         if (cmd.claim) begin
            used_ff <= used_ff + USED_W'(1);
         end
         if (cmd.take_hit || cmd.shift_setup) begin
            hpend_ff <= 1'b0;
         end else if (cmd.sweep) begin
            hpend_ff <= sweep_issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      if (scan_issue) begin
         cmp_idx_ff <= idx_ff[ENTRY_W-1:0];
      end
      if (cmd.take_hit) begin
         entry_ff <= cmp_idx_ff;
         base_ff  <= HADDR_W'(cmp_idx_ff) * HADDR_W'(HISTORY_SLOTS);
      end
      if (cmd.claim) begin
         entry_ff   <= used_ff[ENTRY_W-1:0];
         base_ff    <= HADDR_W'(used_ff) * HADDR_W'(HISTORY_SLOTS);
         wr_slot_ff <= '0;
      end
      // The count read issued with take_hit is registered in hcnt_rd_ff before load_count copies it.
      if (cmd.load_count) begin
         cnt_ff     <= hcnt_rd_ff;
         rd_slot_ff <= '0;
         wr_slot_ff <= '0;
      end
      if (cmd.shift_setup) begin
         cnt_ff     <= CNT_W'(HISTORY_SLOTS);
         rd_slot_ff <= CNT_W'(1);
         wr_slot_ff <= '0;
      end
      if (sweep_issue) begin
         rd_slot_ff <= rd_slot_ff + CNT_W'(1);
      end
      if (cmd.sweep && hpend_ff && keep) begin
         wr_slot_ff <= wr_slot_ff + CNT_W'(1);
      end
      if (cmd.append) begin
         rsp_ff.alert        <= alert_now;
         rsp_ff.dropped      <= 1'b0;
         rsp_ff.recent_count <= RECENT_W'(final_cnt);
      end else if (cmd.drop) begin
         rsp_ff.alert        <= 1'b0;
         rsp_ff.dropped      <= 1'b1;
         rsp_ff.recent_count <= '0;
      end
   end

endmodule

// ===== sv/syn_rate_window_detector.sv =====
// Top level of the SYN rate window detector.
// Depends on swrd_pkg, swrd_ctrl and swrd_datapath.
`timescale 1ns / 1ps
//
// Counts TCP SYN beats per source address over a sliding time window.
// Input channel: a beat (source_address, now_seconds) on req_item is taken
// at a rising edge with start high and busy low. Result channel: rsp_valid
// is high for exactly one cycle with alert, dropped and recent_count on
// rsp_item; the receiver cannot hold it off and needs none.
// Configuration: csr_we, csr_index and csr_wdata write window_seconds or
// alert_threshold at the edge where csr_we is high; write only while idle.
// One beat is worked on at a time. The address tags are scanned one entry
// per cycle through the single read port of the tag memory, and the stored
// timestamps are swept one slot per cycle through the timestamp memory.
// A history that stays full adds a second pass that shifts out its oldest
// slot. busy drops in the cycle the result strobe is shown, so the next
// beat may be taken then. Reset empties the table and loads the register
// defaults (window 5, threshold 10); it needs no clearing pass.
//
module syn_rate_window_detector #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int HISTORY_SLOTS = 16,
   parameter int TIME_WIDTH    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  swrd_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   output swrd_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_we,
   input  swrd_pkg::csr_index_type         csr_index,
   input  logic [swrd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import swrd_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   swrd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   swrd_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .HISTORY_SLOTS (HISTORY_SLOTS),
      .TIME_WIDTH    (TIME_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

`ifndef ASSERT_OFF
   // A result is only shown once the controller is back in idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted beat did not make the block busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("more than one result beat for one item");

   a_drop_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.dropped || rsp_item.alert))
         |-> (rsp_item.recent_count == '0 && !(rsp_item.dropped && rsp_item.alert)))
      else $error("dropped or alert beat with nonzero count");
`endif

endmodule
